[rtl/priority_request_queue_unit_assert.svh]
// Assertion macros used by the priority request queue top level
`ifndef PRIORITY_REQUEST_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_REQUEST_QUEUE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that the consequent holds in the same cycle as the antecedent
`define PRQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("priority request queue assertion failed");
// Check that the consequent holds in the cycle after the antecedent
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("priority request queue assertion failed");
`else
`define PRQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/prq_pkg.sv]
// Shared types and constants of the priority request queue
package prq_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int FLOOR_W  = 8;
   localparam int PRIO_W   = 8;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   localparam logic [FLOOR_W-1:0] TOP_FLOOR_RESET = 8'd100;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_RAISED   = 3'd1,
      ST_SAME     = 3'd2,
      ST_BADFLOOR = 3'd3,
      ST_FULL     = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   typedef struct packed {
      logic [FLOOR_W-1:0] floor;
      logic [PRIO_W-1:0]  prio;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               strobe;
      status_type         status;
      logic [FLOOR_W-1:0] floor;
      logic [PRIO_W-1:0]  prio;
      logic               found;
      logic [COUNT_W-1:0] count;
   } resp_type;

endpackage

[rtl/prq_ram.sv]
// Simple dual-port synchronous RAM with registered read data
module prq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/prq_ctrl.sv]
// Command sequencer: scans, shifts and pops the sorted entry memory
module prq_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [prq_pkg::CMD_W-1:0]           cmd,
   input  logic [prq_pkg::FLOOR_W-1:0]         floor,
   input  logic [prq_pkg::PRIO_W-1:0]          prio,
   input  logic [prq_pkg::FLOOR_W-1:0]         top_floor,
   output prq_pkg::resp_type                   resp,
   output logic                                mem_wr_en,
   output logic [prq_pkg::IDX_W-1:0]           mem_wr_addr,
   output prq_pkg::entry_type                  mem_wr_data,
   output logic                                mem_rd_en,
   output logic [prq_pkg::IDX_W-1:0]           mem_rd_addr,
   input  prq_pkg::entry_type                  mem_rd_data
);

   localparam int IDX_W   = prq_pkg::IDX_W;
   localparam int CNT_W   = prq_pkg::CNT_W;
   localparam int COUNT_W = prq_pkg::COUNT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_POP
   } state_type;

   state_type                   state_ff,    state_in;
   prq_pkg::cmd_type            cmd_ff,      cmd_in;
   logic [prq_pkg::FLOOR_W-1:0] floor_ff,    floor_in;
   logic [prq_pkg::PRIO_W-1:0]  prio_ff,     prio_in;
   logic [CNT_W-1:0]            count_ff,    count_in;
   logic [CNT_W-1:0]            rd_idx_ff,   rd_idx_in;
   logic                        pend_ff,     pend_in;
   logic [IDX_W-1:0]            pend_idx_ff, pend_idx_in;
   logic                        hit_ff,      hit_in;
   logic [IDX_W-1:0]            hit_idx_ff,  hit_idx_in;
   logic [prq_pkg::PRIO_W-1:0]  hit_prio_ff, hit_prio_in;
   logic [CNT_W-1:0]            pos_ff,      pos_in;
   logic                        grow_ff,     grow_in;
   prq_pkg::entry_type          head_ff,     head_in;
   prq_pkg::resp_type           resp_ff,     resp_in;

   logic [CNT_W-1:0] rd_prev;
   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] count_dec;

   // build one response word
   function automatic prq_pkg::resp_type make_resp(
      input prq_pkg::status_type st,
      input prq_pkg::entry_type  ent,
      input logic                fnd,
      input logic [CNT_W-1:0]    cnt
   );
      prq_pkg::resp_type r;
      r.strobe = 1'b1;
      r.status = st;
      r.floor  = ent.floor;
      r.prio   = ent.prio;
      r.found  = fnd;
      r.count  = (COUNT_W)'(cnt);
      return r;
   endfunction

   assign rd_prev   = rd_idx_ff - (CNT_W)'(1);
   assign count_inc = count_ff + (CNT_W)'(1);
   assign count_dec = count_ff - (CNT_W)'(1);
   assign busy      = (state_ff != S_IDLE);
   assign resp      = resp_ff;

   // next-state logic; reads and writes never touch the same entry in a cycle,
   // since shifts read one entry ahead of the one being written
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      floor_in    = floor_ff;
      prio_in     = prio_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_prio_in = hit_prio_ff;
      pos_in      = pos_ff;
      grow_in     = grow_ff;
      head_in     = head_ff;
      resp_in        = resp_ff;
      resp_in.strobe = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_idx_ff[IDX_W-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = pend_idx_ff;
      mem_wr_data = mem_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = prq_pkg::cmd_type'(cmd);
               floor_in  = floor;
               prio_in   = prio;
               rd_idx_in = '0;
               hit_in    = 1'b0;
               pos_in    = '0;
               head_in   = '0;
               case (prq_pkg::cmd_type'(cmd))
                  prq_pkg::CMD_ADD: begin
                     if ((floor == '0) || (floor > top_floor)) begin
                        resp_in = make_resp(prq_pkg::ST_BADFLOOR, '0, 1'b0, count_ff);
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  prq_pkg::CMD_QUERY: begin
                     state_in = S_SCAN;
                  end
                  prq_pkg::CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        resp_in = make_resp(prq_pkg::ST_EMPTY, '0, 1'b0, count_ff);
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  default: begin
                     resp_in = make_resp(prq_pkg::ST_OK, '0, 1'b0, count_ff);
                  end
               endcase
            end
         end

         S_SCAN: begin
            // stream entries out, look for the floor and count ones of equal or higher priority
            if (rd_idx_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_idx_ff[IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + (CNT_W)'(1);
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               if ((mem_rd_data.floor == floor_ff) && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = pend_idx_ff;
                  hit_prio_in = mem_rd_data.prio;
               end
               if (mem_rd_data.prio >= prio_ff) begin
                  pos_in = pos_ff + (CNT_W)'(1);
               end
            end else if (rd_idx_ff == count_ff) begin
               // scan complete: decide the outcome
               state_in = S_IDLE;
               if (cmd_ff == prq_pkg::CMD_QUERY) begin
                  resp_in = make_resp(prq_pkg::ST_OK, '0, hit_ff, count_ff);
               end else if (hit_ff) begin
                  if (prio_ff > hit_prio_ff) begin
                     grow_in   = 1'b0;
                     rd_idx_in = (CNT_W)'(hit_idx_ff);
                     state_in  = S_SHIFT;
                  end else begin
                     resp_in = make_resp(prq_pkg::ST_SAME, '0, 1'b0, count_ff);
                  end
               end else if (count_ff == (CNT_W)'(prq_pkg::DEPTH)) begin
                  resp_in = make_resp(prq_pkg::ST_FULL, '0, 1'b0, count_ff);
               end else begin
                  grow_in   = 1'b1;
                  rd_idx_in = count_ff;
                  state_in  = S_SHIFT;
               end
            end
         end

         S_SHIFT: begin
            // move the entry at the slot and those below it up by one, top first
            if (rd_idx_ff > pos_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_prev[IDX_W-1:0];
               rd_idx_in   = rd_prev;
               pend_in     = 1'b1;
               pend_idx_in = rd_prev[IDX_W-1:0];
            end
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pend_idx_ff + (IDX_W)'(1);
               mem_wr_data = mem_rd_data;
            end else if (rd_idx_ff == pos_ff) begin
               // drop the new or raised request into its slot
               mem_wr_en         = 1'b1;
               mem_wr_addr       = pos_ff[IDX_W-1:0];
               mem_wr_data.floor = floor_ff;
               mem_wr_data.prio  = prio_ff;
               state_in          = S_IDLE;
               if (grow_ff) begin
                  count_in = count_inc;
                  resp_in  = make_resp(prq_pkg::ST_OK, '0, 1'b0, count_inc);
               end else begin
                  resp_in  = make_resp(prq_pkg::ST_RAISED, '0, 1'b0, count_ff);
               end
            end
         end

         S_POP: begin
            // take the head, move every other entry down by one
            if (rd_idx_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_idx_ff[IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + (CNT_W)'(1);
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               if (pend_idx_ff == '0) begin
                  head_in = mem_rd_data;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = pend_idx_ff - (IDX_W)'(1);
                  mem_wr_data = mem_rd_data;
               end
            end else if (rd_idx_ff == count_ff) begin
               count_in = count_dec;
               resp_in  = make_resp(prq_pkg::ST_OK, head_ff, 1'b0, count_dec);
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         resp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         resp_ff  <= resp_in;
      end
      cmd_ff      <= cmd_in;
      floor_ff    <= floor_in;
      prio_ff     <= prio_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_prio_ff <= hit_prio_in;
      pos_ff      <= pos_in;
      grow_ff     <= grow_in;
      head_ff     <= head_in;
   end

endmodule

[rtl/priority_request_queue_unit.sv]
// Top level of the priority request queue: floor limit register, sequencer, entry RAM
//
// A priority queue of up to 16 floor requests, highest priority first, older first
// among equal priorities. A request (req_cmd, req_floor, req_priority_req) is taken
// on a clock edge where start is high and busy is low. Commands: add, remove head,
// query floor. csr_we with csr_wdata sets the highest floor that add accepts; write
// it only while the block is idle.
// Every request gives exactly one response, shown on the rsp_ ports for one cycle
// while rsp_strobe is high; the receiver cannot stall it, so it must take it then.
// Rejected adds for a bad floor, unused commands and removes on an empty queue are
// answered from idle, with busy staying low.
// The entries live in one RAM with a read and a write port; scans and shifts move
// one entry a cycle through it, so cost grows with the fill level. For all other
// requests busy is high from the cycle after accept until the response is strobed.
// Reset empties the queue and sets the floor limit to 100; RAM contents are not
// cleared, since only entries below the count are ever read.
`include "priority_request_queue_unit_assert.svh"
module priority_request_queue_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_floor,
   input  logic [7:0] req_priority_req,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output logic       rsp_strobe,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_out_floor,
   output logic [7:0] rsp_out_priority,
   output logic       rsp_found,
   output logic [4:0] rsp_count
);

   logic [prq_pkg::FLOOR_W-1:0] top_floor_ff;
   prq_pkg::resp_type           resp;
   logic                        mem_wr_en;
   logic [prq_pkg::IDX_W-1:0]   mem_wr_addr;
   prq_pkg::entry_type          mem_wr_data;
   logic                        mem_rd_en;
   logic [prq_pkg::IDX_W-1:0]   mem_rd_addr;
   prq_pkg::entry_type          mem_rd_data;

   logic                        none_accept;
   logic                        query_accept;
   logic                        count_in_range;
   logic                        count_at_depth;
   logic                        resp_full;

   // hold the floor limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         top_floor_ff <= prq_pkg::TOP_FLOOR_RESET;
      end else if (csr_we) begin
         top_floor_ff <= csr_wdata;
      end
   end

   prq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .cmd         (req_cmd),
      .floor       (req_floor),
      .prio        (req_priority_req),
      .top_floor   (top_floor_ff),
      .resp        (resp),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   prq_ram #(
      .WIDTH (prq_pkg::ENTRY_W),
      .DEPTH (prq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // unpack the response
   assign rsp_strobe       = resp.strobe;
   assign rsp_status       = resp.status;
   assign rsp_out_floor    = resp.floor;
   assign rsp_out_priority = resp.prio;
   assign rsp_found        = resp.found;
   assign rsp_count        = resp.count;

   // flag the accepted commands and count limits the checks look at
   assign none_accept    = start && !busy && (req_cmd == prq_pkg::CMD_NONE);
   assign query_accept   = start && !busy && (req_cmd == prq_pkg::CMD_QUERY);
   assign count_in_range = (rsp_count <= (prq_pkg::COUNT_W)'(prq_pkg::DEPTH));
   assign count_at_depth = (rsp_count == (prq_pkg::COUNT_W)'(prq_pkg::DEPTH));
   assign resp_full      = rsp_strobe && (rsp_status == prq_pkg::ST_FULL);

   `PRQ_ASSERT_SAME(a_count_bound, clock, reset, rsp_strobe, count_in_range)
   `PRQ_ASSERT_SAME(a_full_count, clock, reset, resp_full, count_at_depth)
   `PRQ_ASSERT_NEXT(a_unused_cmd_resp, clock, reset, none_accept, rsp_strobe && !busy)
   `PRQ_ASSERT_NEXT(a_query_busy, clock, reset, query_accept, busy && !rsp_strobe)

endmodule

[tb/priority_request_queue_unit_tb.sv]
// Testbench for the priority request queue: directed table, then random phases
`timescale 1ns / 1ps

module priority_request_queue_unit_tb;

   localparam int STALL_LIMIT = 3000;
   localparam int PHASE_ITEMS = 260;

   typedef struct packed {
      prq_pkg::status_type         status;
      logic [prq_pkg::FLOOR_W-1:0] floor;
      logic [prq_pkg::PRIO_W-1:0]  prio;
      logic                        found;
      logic [prq_pkg::COUNT_W-1:0] count;
   } queue_result_type;

   typedef struct packed {
      prq_pkg::cmd_type            cmd;
      logic [prq_pkg::FLOOR_W-1:0] floor;
      logic [prq_pkg::PRIO_W-1:0]  prio;
      logic                        typed;
      queue_result_type            want;
   } table_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_cmd;
   logic [7:0]         req_floor;
   logic [7:0]         req_priority_req;
   logic               csr_we;
   logic [7:0]         csr_wdata;
   logic               rsp_strobe;
   logic [2:0]         rsp_status;
   logic [7:0]         rsp_out_floor;
   logic [7:0]         rsp_out_priority;
   logic               rsp_found;
   logic [4:0]         rsp_count;

   // side band: a typed expectation travels with the request it belongs to
   logic               row_typed;
   queue_result_type   row_want;

   // predictor state
   logic [prq_pkg::FLOOR_W-1:0] fl_store [prq_pkg::DEPTH];
   logic [prq_pkg::PRIO_W-1:0]  pr_store [prq_pkg::DEPTH];
   int                          held;
   logic [prq_pkg::FLOOR_W-1:0] floor_limit;

   queue_result_type   pending_results[$];
   table_row_type      stim_table[$];
   int                 errors;
   int                 stall_cycles;

   priority_request_queue_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_floor        (req_floor),
      .req_priority_req (req_priority_req),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_floor    (rsp_out_floor),
      .rsp_out_priority (rsp_out_priority),
      .rsp_found        (rsp_found),
      .rsp_count        (rsp_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Find the slot holding a floor; held if absent
   function automatic int slot_of(input logic [prq_pkg::FLOOR_W-1:0] fl);
      int i;
      for (i = 0; i < held; i++)
         if (fl_store[i] == fl) return i;
      return held;
   endfunction

   // Slot after every entry with priority at or above pr
   function automatic int ordered_slot(input logic [prq_pkg::PRIO_W-1:0] pr);
      int i;
      i = 0;
      while (i < held && pr_store[i] >= pr) i++;
      return i;
   endfunction

   function automatic void drop_slot(input int pos);
      int i;
      for (i = pos; i + 1 < held; i++) begin
         fl_store[i] = fl_store[i+1];
         pr_store[i] = pr_store[i+1];
      end
      held--;
   endfunction

   function automatic void place_entry(input logic [prq_pkg::FLOOR_W-1:0] fl,
                                       input logic [prq_pkg::PRIO_W-1:0] pr);
      int pos;
      int i;
      pos = ordered_slot(pr);
      for (i = held; i > pos; i--) begin
         fl_store[i] = fl_store[i-1];
         pr_store[i] = pr_store[i-1];
      end
      fl_store[pos] = fl;
      pr_store[pos] = pr;
      held++;
   endfunction

   // Apply one request to the predicted queue and return its response
   function automatic queue_result_type serve_request(
      input prq_pkg::cmd_type c,
      input logic [prq_pkg::FLOOR_W-1:0] fl,
      input logic [prq_pkg::PRIO_W-1:0] pr
   );
      queue_result_type r;
      int idx;
      r = '0;
      r.status = prq_pkg::ST_OK;
      case (c)
         prq_pkg::CMD_ADD: begin
            if (fl == 0 || fl > floor_limit) begin
               r.status = prq_pkg::ST_BADFLOOR;
            end else begin
               idx = slot_of(fl);
               if (idx < held) begin
                  if (pr > pr_store[idx]) begin
                     drop_slot(idx);
                     place_entry(fl, pr);
                     r.status = prq_pkg::ST_RAISED;
                  end else begin
                     r.status = prq_pkg::ST_SAME;
                  end
               end else if (held >= prq_pkg::DEPTH) begin
                  r.status = prq_pkg::ST_FULL;
               end else begin
                  place_entry(fl, pr);
               end
            end
         end
         prq_pkg::CMD_REMOVE: begin
            if (held == 0) begin
               r.status = prq_pkg::ST_EMPTY;
            end else begin
               r.floor = fl_store[0];
               r.prio  = pr_store[0];
               drop_slot(0);
            end
         end
         prq_pkg::CMD_QUERY: begin
            r.found = (slot_of(fl) < held);
         end
         default: ;
      endcase
      r.count = held[prq_pkg::COUNT_W-1:0];
      return r;
   endfunction

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Check responses, track config, predict accepted requests, count stalls
   always @(posedge clock) begin : monitor
      queue_result_type want;
      if (reset) begin
         held = 0;
         floor_limit = prq_pkg::TOP_FLOOR_RESET;
         pending_results.delete();
         stall_cycles = 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response with none expected, status %0d floor %0d",
                        $time, rsp_status, rsp_out_floor);
               errors++;
            end else begin
               want = pending_results.pop_front();
               report_field("status", want.status, rsp_status);
               report_field("out_floor", want.floor, rsp_out_floor);
               report_field("out_priority", want.prio, rsp_out_priority);
               report_field("found", want.found, rsp_found);
               report_field("count", want.count, rsp_count);
            end
         end
         if (csr_we) floor_limit = csr_wdata;
         if (start && !busy) begin
            want = serve_request(prq_pkg::cmd_type'(req_cmd), req_floor, req_priority_req);
            if (row_typed) want = row_want;
            pending_results.push_back(want);
         end
         if ((start && !busy) || rsp_strobe) stall_cycles = 0;
         else stall_cycles++;
      end
   end

   // End the run when nothing moves for too long
   initial begin : watchdog
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   // Present one request and hold it until accepted
   task automatic issue(input prq_pkg::cmd_type c, input logic [prq_pkg::FLOOR_W-1:0] fl,
                        input logic [prq_pkg::PRIO_W-1:0] pr, input logic typed,
                        input queue_result_type w, input bit may_idle);
      if (may_idle)
         while ($urandom_range(99) < 26) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start            <= 1'b1;
      req_cmd          <= c;
      req_floor        <= fl;
      req_priority_req <= pr;
      row_typed        <= typed;
      row_want         <= w;
      do @(posedge clock); while (busy);
   endtask

   // Drain outstanding responses and let the block settle
   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_row(input prq_pkg::cmd_type c, input logic [7:0] fl,
                          input logic [7:0] pr, input logic typed,
                          input prq_pkg::status_type st, input logic [7:0] of,
                          input logic [7:0] op, input logic fnd, input logic [4:0] cnt);
      table_row_type row;
      row.cmd         = c;
      row.floor       = fl;
      row.prio        = pr;
      row.typed       = typed;
      row.want.status = st;
      row.want.floor  = of;
      row.want.prio   = op;
      row.want.found  = fnd;
      row.want.count  = cnt;
      stim_table.push_back(row);
   endtask

   // Pick a floor, mostly from a small valid pool so entries collide
   function automatic logic [7:0] pick_floor(input logic [7:0] lim);
      int top;
      top = (lim > 20) ? 20 : lim;
      if (lim != 0 && $urandom_range(99) < 70) return 8'($urandom_range(top, 1));
      return 8'($urandom_range(255, 0));
   endfunction

   function automatic logic [7:0] pick_prio();
      int r;
      r = $urandom_range(99);
      if (r < 40) return 8'($urandom_range(3, 0));
      if (r < 50) return 8'd0;
      if (r < 60) return 8'd255;
      return 8'($urandom_range(255, 0));
   endfunction

   initial begin : stimulus
      logic [7:0]       limits [6];
      int               add_pct [6];
      logic [7:0]       lim;
      int               p;
      int               n;
      int               r;
      prq_pkg::cmd_type c;
      queue_result_type none;

      errors = 0;
      none   = '0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_cmd          <= prq_pkg::CMD_ADD;
      req_floor        <= '0;
      req_priority_req <= '0;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;
      row_typed        <= 1'b0;
      row_want         <= '0;

      // directed table; rows with typed == 0 are checked by the predictor
      add_row(prq_pkg::CMD_REMOVE, 8'd0,   8'd0,   1, prq_pkg::ST_EMPTY,    0,   0,   0, 0);
      add_row(prq_pkg::CMD_QUERY,  8'd5,   8'd0,   1, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_QUERY,  8'd0,   8'd255, 1, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_ADD,    8'd0,   8'd10,  1, prq_pkg::ST_BADFLOOR, 0,   0,   0, 0);
      add_row(prq_pkg::CMD_ADD,    8'd101, 8'd10,  1, prq_pkg::ST_BADFLOOR, 0,   0,   0, 0);
      add_row(prq_pkg::CMD_ADD,    8'd255, 8'd255, 1, prq_pkg::ST_BADFLOOR, 0,   0,   0, 0);
      add_row(prq_pkg::CMD_ADD,    8'd100, 8'd255, 1, prq_pkg::ST_OK,       0,   0,   0, 1);
      add_row(prq_pkg::CMD_ADD,    8'd100, 8'd255, 1, prq_pkg::ST_SAME,     0,   0,   0, 1);
      add_row(prq_pkg::CMD_ADD,    8'd1,   8'd0,   1, prq_pkg::ST_OK,       0,   0,   0, 2);
      add_row(prq_pkg::CMD_ADD,    8'd1,   8'd0,   1, prq_pkg::ST_SAME,     0,   0,   0, 2);
      add_row(prq_pkg::CMD_ADD,    8'd50,  8'd128, 0, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_ADD,    8'd51,  8'd128, 0, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_ADD,    8'd1,   8'd128, 0, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_ADD,    8'd51,  8'd127, 0, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_QUERY,  8'd51,  8'd0,   0, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_QUERY,  8'd200, 8'd0,   0, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_NONE,   8'd255, 8'd255, 1, prq_pkg::ST_OK,       0,   0,   0, 4);
      add_row(prq_pkg::CMD_REMOVE, 8'd77,  8'd77,  1, prq_pkg::ST_OK,       100, 255, 0, 3);
      add_row(prq_pkg::CMD_REMOVE, 8'd0,   8'd0,   0, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_REMOVE, 8'd0,   8'd0,   0, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_REMOVE, 8'd0,   8'd0,   0, prq_pkg::ST_OK,       0,   0,   0, 0);
      add_row(prq_pkg::CMD_REMOVE, 8'd0,   8'd0,   1, prq_pkg::ST_EMPTY,    0,   0,   0, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i])
         issue(stim_table[i].cmd, stim_table[i].floor, stim_table[i].prio,
               stim_table[i].typed, stim_table[i].want, 1'b1);

      // random phases, each under its own floor limit and command mix
      limits[0] = 8'd255; add_pct[0] = 80;
      limits[1] = 8'd1;   add_pct[1] = 50;
      limits[2] = 8'd0;   add_pct[2] = 45;
      limits[3] = 8'd16;  add_pct[3] = 75;
      limits[4] = 8'd100; add_pct[4] = 30;
      limits[5] = 8'($urandom_range(255, 1)); add_pct[5] = 60;
      for (p = 0; p < 6; p++) begin
         lim = limits[p];
         write_limit(lim);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < add_pct[p]) c = prq_pkg::CMD_ADD;
            else if (r < 97)
               c = ($urandom_range(1) != 0) ? prq_pkg::CMD_REMOVE : prq_pkg::CMD_QUERY;
            else c = prq_pkg::CMD_NONE;
            // run the fourth phase without any gaps
            issue(c, pick_floor(lim), pick_prio(), 1'b0, none, p != 3);
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/prq_ctrl.sv
rtl/priority_request_queue_unit.sv
tb/priority_request_queue_unit_tb.sv
